/* rtl/acc_pkg.sv */
// Package for the accumulator ALU fold block.
// Holds opcode constants and the command and status structs between controller and datapath.
// No dependencies.
package acc_pkg;

    localparam int OPCODE_W = 3;

    localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REM = 3'd4;

    typedef struct packed {
        logic load_in;
        logic step;
        logic commit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic iterative;
        logic last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/acc_if.sv */
// Valid/ready channel interfaces for the accumulator ALU fold block.
// Operand channel and result channel; uses acc_pkg for the opcode width.
interface acc_in_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic                         load_first;
    logic [acc_pkg::OPCODE_W-1:0] opcode;
    logic signed [DATA_WIDTH-1:0] operand;
    logic                         last;

    modport source (output valid, load_first, opcode, operand, last, input ready);
    modport sink   (input valid, load_first, opcode, operand, last, output ready);
endinterface

interface acc_out_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         divide_by_zero;

    modport source (output valid, result, divide_by_zero, input ready);
    modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

/* rtl/accumulator_alu_fold.sv */
// Accumulator ALU fold: one item at a time; add, subtract, load and unused opcodes pass
// through the execute and finish states before the next accept; multiply, divide and remainder
// also run DATA_WIDTH steps of the one-bit-per-cycle shift-add/subtract unit in execute.
// A result is registered into the output register when the finish state commits a last beat;
// a full output register holds the block until it drains.
// Synchronous active-low reset clears accumulator, error flag and output valid.
module accumulator_alu_fold #(
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acc_in_if.sink     i_in,
    acc_out_if.source  o_out
);

    acc_pkg::t_cmd w_cmd;
    acc_pkg::t_sts w_sts;

    acc_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in.valid),
        .o_ready(i_in.ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    acc_dp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_load_first    (i_in.load_first),
        .i_opcode        (i_in.opcode),
        .i_operand       (i_in.operand),
        .i_last          (i_in.last),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_result        (o_out.result),
        .o_divide_by_zero(o_out.divide_by_zero)
    );

endmodule

/* rtl/acc_ctrl.sv */
// Controller state machine for the accumulator ALU fold block.
// Sequences accept, iteration and commit; depends on acc_pkg.
module acc_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  acc_pkg::t_sts i_sts,
    output acc_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = CNT_W'(DATA_WIDTH);
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.iterative) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!i_sts.last || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.emit   = i_sts.last;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted beat did not start execution");

    a_exec_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_cnt != '0))
        else $error("iteration count exhausted while executing");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (i_sts.out_free && o_cmd.commit))
        else $error("result emitted without a free output slot");
`endif

endmodule

/* rtl/acc_dp.sv */
// Datapath for the accumulator ALU fold block: accumulator, error flag,
// shift-add multiplier, restoring divider and output register. Depends on acc_pkg.
module acc_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  acc_pkg::t_cmd                i_cmd,
    output acc_pkg::t_sts                o_sts,
    input  logic                         i_load_first,
    input  logic [acc_pkg::OPCODE_W-1:0] i_opcode,
    input  logic signed [DATA_WIDTH-1:0] i_operand,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_divide_by_zero
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0]                 r_acc, n_acc;
    logic                         r_err, n_err;
    logic                         r_load;
    logic [acc_pkg::OPCODE_W-1:0] r_op;
    logic [W-1:0]                 r_b;
    logic                         r_last;
    logic [W-1:0]                 r_hi, r_lo, r_opnd;
    logic [W-1:0]                 n_hi, n_lo, n_opnd;
    logic [W-1:0]                 r_res;
    logic                         r_dbz;
    logic                         r_out_valid;

    logic [W-1:0] w_acc_mag, w_in_mag, w_quo_s, w_rem_s;
    logic [W:0]   w_trial, w_diff;
    logic         w_fits, w_in_div, w_is_div, w_is_mul;

    assign w_acc_mag = r_acc[W-1] ? (W'(0) - r_acc) : r_acc;
    assign w_in_mag  = i_operand[W-1] ? (W'(0) - W'(i_operand)) : W'(i_operand);
    assign w_in_div  = (i_opcode == acc_pkg::OP_DIV) || (i_opcode == acc_pkg::OP_REM);
    assign w_is_div  = (r_op == acc_pkg::OP_DIV) || (r_op == acc_pkg::OP_REM);
    assign w_is_mul  = (r_op == acc_pkg::OP_MUL);

    assign w_trial = {r_hi, r_lo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_opnd};
    assign w_fits  = (w_trial >= {1'b0, r_opnd});

    assign w_quo_s = (r_acc[W-1] ^ r_b[W-1]) ? (W'(0) - r_lo) : r_lo;
    assign w_rem_s = r_acc[W-1] ? (W'(0) - r_hi) : r_hi;

    assign o_sts.iterative = !r_load && (w_is_mul || w_is_div);
    assign o_sts.last      = r_last;
    assign o_sts.out_free  = !r_out_valid || i_ready;

    always_comb begin
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_opnd = r_opnd;
        if (i_cmd.load_in) begin
            n_hi = '0;
            if (w_in_div) begin
                n_lo   = w_acc_mag;
                n_opnd = w_in_mag;
            end else begin
                n_lo   = W'(i_operand);
                n_opnd = r_acc;
            end
        end else if (i_cmd.step) begin
            if (w_is_div) begin
                n_hi = w_fits ? w_diff[W-1:0] : w_trial[W-1:0];
                n_lo = {r_lo[W-2:0], w_fits};
            end else begin
                n_hi   = r_hi + (r_lo[0] ? r_opnd : '0);
                n_lo   = r_lo >> 1;
                n_opnd = r_opnd << 1;
            end
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (r_load) begin
            n_acc = r_b;
            n_err = 1'b0;
        end else begin
            case (r_op)
                acc_pkg::OP_ADD: n_acc = r_acc + r_b;
                acc_pkg::OP_SUB: n_acc = r_acc - r_b;
                acc_pkg::OP_MUL: n_acc = r_hi;
                acc_pkg::OP_DIV: begin
                    if (r_b == '0) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc = w_quo_s;
                    end
                end
                acc_pkg::OP_REM: begin
                    if (r_b == '0) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc = w_rem_s;
                    end
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_load <= i_load_first;
            r_op   <= i_opcode;
            r_b    <= W'(i_operand);
            r_last <= i_last;
        end
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_opnd <= n_opnd;
        if (i_cmd.emit) begin
            r_res <= n_acc;
            r_dbz <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_acc <= n_acc;
                r_err <= n_err;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result         = r_res;
    assign o_divide_by_zero = r_dbz;

`ifndef SYNTHESIS
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_load) |=> (!r_err && (r_acc == $past(r_b))))
        else $error("load did not set accumulator and clear error");

    a_zero_div_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_load && w_is_div && (r_b == '0))
            |=> (r_err && $stable(r_acc)))
        else $error("zero divisor did not hold accumulator and set error");
`endif

endmodule
